// File: rtl/dcnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_pkg
// Shared types, codes and character helpers of the DIMACS CNF tokenizer.
// ----------------------------------------------------------------------------
package dcnf_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned OUT_WIDTH       = 32;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned QIDX_W          = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_P       = 8'h70;

    // header: the 'p' byte plus four more are skipped
    localparam logic [2:0] HDR_SKIP   = 3'd4;

    typedef enum logic [6:0] {
        M_START   = 7'b0000001,
        M_COMMENT = 7'b0000010,
        M_HSKIP   = 7'b0000100,
        M_HDR_PRE = 7'b0001000,
        M_HDR_DIG = 7'b0010000,
        M_LIT     = 7'b0100000,
        M_ERROR   = 7'b1000000
    } t_mode;

    typedef enum logic [2:0] {
        K_LIT   = 3'd0,
        K_CEND  = 3'd1,
        K_HVARS = 3'd2,
        K_HCLS  = 3'd3,
        K_ERR   = 3'd4,
        K_TOTAL = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [OUT_WIDTH-1:0]  value;
        logic                  mismatch;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result mk_res(t_kind k, logic [OUT_WIDTH-1:0] v, logic m);
        t_result r;
        r.kind     = k;
        r.value    = v;
        r.mismatch = m;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// File: rtl/dcnf_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_stream_if
// Valid/ready channels: text bytes in, tokens out.
// ----------------------------------------------------------------------------
interface dcnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface dcnf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] token_value;
    logic        count_mismatch;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_value,
                    output count_mismatch, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input count_mismatch, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/dimacs_cnf_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dimacs_cnf_tokenizer
// Scans DIMACS CNF text a byte per request and emits literals, clause ends,
// header counts, the clause total and parse errors.
// ----------------------------------------------------------------------------
// Tokens are registered in the result queue and offered on o_out in order.
// Throughput: one byte per cycle while i_in.ready is high; the two tokens of
//   one byte leave one by one from the single-read result queue (4 entries).
// i_in.ready drops while the queue holds more than two tokens.
// Reset (synchronous): scanner back to token start, counters cleared,
//   queue emptied.
module dimacs_cnf_tokenizer #(
    parameter int unsigned VALUE_WIDTH = dcnf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dcnf_in_if.sink    i_in,
    dcnf_out_if.source o_out
);
    import dcnf_pkg::*;

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned XW = (W > OUT_WIDTH) ? W : OUT_WIDTH;
    localparam logic [W-2:0] MAG_MAX = '1;

    t_mode        r_mode, n_mode;
    logic [2:0]   r_skip, n_skip;
    logic [W-2:0] r_acc, n_acc;
    logic         r_neg, n_neg;
    logic [W-2:0] r_total, n_total;
    logic [W-1:0] r_hcc, n_hcc;

    logic         w_fire;
    logic         w_room;
    logic         w_qroom;
    logic [W-1:0] w_num;
    logic [W-2:0] w_total_inc;
    logic [7:0]   w_c;
    logic         w_c_digit;
    logic         w_c_num;

    logic         v_fail;
    logic         v_done;
    logic [1:0]   v_n;
    t_result      v_r0, v_r1;
    t_push        w_push;
    t_result      w_head;
    logic         w_qvalid;

    function automatic logic [W-2:0] acc_next(logic [W-2:0] a, logic [3:0] d);
        logic [W+2:0] s;
        s = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + (W+3)'(d);
        return (s > (W+3)'(MAG_MAX)) ? MAG_MAX : s[W-2:0];
    endfunction

    function automatic logic [OUT_WIDTH-1:0] to_out(logic [W-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[OUT_WIDTH-1:0];
    endfunction

    assign w_room      = 1'b1 & w_qroom;
    assign w_fire      = i_in.valid & i_in.ready;
    assign w_c         = i_in.text_byte;
    assign w_c_digit   = is_digit(w_c);
    assign w_c_num     = w_c_digit || (w_c == CH_MINUS);
    assign w_num       = r_neg ? ('0 - {1'b0, r_acc}) : {1'b0, r_acc};
    assign w_total_inc = (r_total != MAG_MAX) ? (r_total + (W-1)'(1)) : r_total;

    always_comb begin
        n_mode  = r_mode;
        n_skip  = r_skip;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_total = r_total;
        n_hcc   = r_hcc;
        v_fail  = 1'b0;
        v_done  = 1'b0;
        v_n     = 2'd0;
        v_r0    = '0;
        v_r1    = '0;

        if (w_fire && (r_mode != M_ERROR)) begin
            if (i_in.end_of_text) begin
                unique case (r_mode)
                    M_COMMENT: begin
                        v_fail = 1'b1;
                    end
                    M_LIT: begin
                        if (r_acc != '0) begin
                            v_fail = 1'b1;
                        end else begin
                            v_r0    = mk_res(K_CEND, '0, 1'b0);
                            v_n     = 2'd1;
                            n_total = w_total_inc;
                        end
                    end
                    M_HDR_PRE: begin
                        n_hcc = '0;
                    end
                    M_HDR_DIG: begin
                        n_hcc = (r_skip != 3'd0) ? w_num : '0;
                    end
                    default: begin
                    end
                endcase
                if (!v_fail) begin
                    if (v_n == 2'd0) begin
                        v_r0 = mk_res(K_TOTAL, to_out({1'b0, n_total}),
                                      ({1'b0, n_total} != n_hcc));
                    end else begin
                        v_r1 = mk_res(K_TOTAL, to_out({1'b0, n_total}),
                                      ({1'b0, n_total} != n_hcc));
                    end
                    v_n     = v_n + 2'd1;
                    n_mode  = M_START;
                    n_skip  = 3'd0;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_total = '0;
                    n_hcc   = '0;
                end
            end else begin
                // first pass: current mode, may close a number
                unique case (r_mode)
                    M_START, M_HDR_PRE: begin
                    end
                    M_COMMENT: begin
                        if (w_c == CH_NEWLINE) begin
                            n_mode = M_START;
                        end
                        v_done = 1'b1;
                    end
                    M_HSKIP: begin
                        n_skip = r_skip - 3'd1;
                        if (n_skip == 3'd0) begin
                            n_mode = M_HDR_PRE;
                        end
                        v_done = 1'b1;
                    end
                    M_HDR_DIG: begin
                        if (w_c_digit) begin
                            n_acc  = acc_next(r_acc, w_c[3:0]);
                            v_done = 1'b1;
                        end else begin
                            n_acc = '0;
                            n_neg = 1'b0;
                            if (r_skip != 3'd0) begin
                                v_r0   = mk_res(K_HCLS, to_out(w_num), 1'b0);
                                n_hcc  = w_num;
                                n_skip = 3'd0;
                                n_mode = M_START;
                            end else begin
                                v_r0   = mk_res(K_HVARS, to_out(w_num), 1'b0);
                                n_skip = 3'd1;
                                n_mode = M_HDR_PRE;
                            end
                            v_n = 2'd1;
                        end
                    end
                    M_LIT: begin
                        if (w_c_digit) begin
                            n_acc  = acc_next(r_acc, w_c[3:0]);
                            v_done = 1'b1;
                        end else begin
                            if (r_acc == '0) begin
                                v_r0    = mk_res(K_CEND, '0, 1'b0);
                                n_total = w_total_inc;
                            end else begin
                                v_r0 = mk_res(K_LIT, to_out(w_num), 1'b0);
                            end
                            v_n    = 2'd1;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                            n_mode = M_START;
                        end
                    end
                    default: begin
                        v_done = 1'b1;
                    end
                endcase

                // header count prefix; a missing count reads as zero
                if (!v_done && (n_mode == M_HDR_PRE)) begin
                    if (is_space(w_c)) begin
                        v_done = 1'b1;
                    end else if (w_c_num) begin
                        n_neg  = (w_c == CH_MINUS);
                        n_acc  = w_c_digit ? (W-1)'(w_c[3:0]) : '0;
                        n_mode = M_HDR_DIG;
                        v_done = 1'b1;
                    end else begin
                        if (n_skip == 3'd0) begin
                            v_r0 = mk_res(K_HVARS, '0, 1'b0);
                            v_r1 = mk_res(K_HCLS, '0, 1'b0);
                            v_n  = 2'd2;
                        end else if (v_n == 2'd0) begin
                            v_r0 = mk_res(K_HCLS, '0, 1'b0);
                            v_n  = 2'd1;
                        end else begin
                            v_r1 = mk_res(K_HCLS, '0, 1'b0);
                            v_n  = 2'd2;
                        end
                        n_hcc  = '0;
                        n_skip = 3'd0;
                        n_mode = M_START;
                    end
                end

                // token start
                if (!v_done && (n_mode == M_START)) begin
                    if (is_space(w_c)) begin
                    end else if (w_c == CH_C) begin
                        n_mode = M_COMMENT;
                    end else if (w_c == CH_P) begin
                        n_mode = M_HSKIP;
                        n_skip = HDR_SKIP;
                    end else if (w_c_num) begin
                        n_neg  = (w_c == CH_MINUS);
                        n_acc  = w_c_digit ? (W-1)'(w_c[3:0]) : '0;
                        n_mode = M_LIT;
                    end else begin
                        v_fail = 1'b1;
                    end
                end
            end

            if (v_fail) begin
                v_r0   = mk_res(K_ERR, '0, 1'b0);
                v_r1   = '0;
                v_n    = 2'd1;
                n_mode = M_ERROR;
            end
            if (v_n == 2'd1) begin
                v_r0.last = 1'b1;
            end else if (v_n == 2'd2) begin
                v_r1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_skip  <= 3'd0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_total <= '0;
            r_hcc   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_skip  <= n_skip;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_total <= n_total;
            r_hcc   <= n_hcc;
        end
    end

    assign w_push.count  = v_n;
    assign w_push.first  = v_r0;
    assign w_push.second = v_r1;

    dcnf_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_qvalid & o_out.ready),
        .o_room  (w_qroom),
        .o_valid (w_qvalid),
        .o_head  (w_head)
    );

    assign i_in.ready           = w_room;
    assign o_out.valid          = w_qvalid;
    assign o_out.token_kind     = w_head.kind;
    assign o_out.token_value    = w_head.value;
    assign o_out.count_mismatch = w_head.mismatch;
    assign o_out.last_of_run    = w_head.last;

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_ERROR) |=> (r_mode == M_ERROR) && (w_push.count == 2'd0))
        else $error("activity after parse error");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |->
            ((w_push.first.kind != K_ERR) && (w_push.second.kind != K_ERR)))
        else $error("parse error paired with another token");

    a_mismatch_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_push.count != 2'd0) && (w_push.first.kind != K_TOTAL))
            |-> !w_push.first.mismatch)
        else $error("mismatch flag on a non-total token");

endmodule
`default_nettype wire

// File: rtl/dcnf_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_result_queue
// Shifting result queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module dcnf_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcnf_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output dcnf_pkg::t_result o_head
);
    import dcnf_pkg::*;

    t_result           r_q [QUEUE_DEPTH];
    t_result           n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic [QCNT_W-1:0] v_base;

    always_comb begin
        v_base = r_cnt - QCNT_W'(i_pop);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            n_q[k] = i_pop ? r_q[k + 1] : r_q[k];
        end
        n_q[QUEUE_DEPTH - 1] = r_q[QUEUE_DEPTH - 1];
        if (i_push.count != 2'd0) begin
            n_q[v_base[QIDX_W-1:0]] = i_push.first;
        end
        if (i_push.count == 2'd2) begin
            n_q[v_base[QIDX_W-1:0] + QIDX_W'(1)] = i_push.second;
        end
        n_cnt = v_base + QCNT_W'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && (i_push.count == 2'd0)) |=> (r_cnt == $past(r_cnt) - QCNT_W'(1)))
        else $error("pop did not drop count");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives DIMACS CNF text into the tokenizer a byte per request, predicts the
// token stream in a scoreboard model, and checks every output token in order.
// Random files with headers, comments, saturating literals and truncated
// headers run under random idling on both channels; one parse error closes
// the run.
// ----------------------------------------------------------------------------
module tb_top;
    import dcnf_pkg::*;

    localparam int unsigned     VW           = VALUE_WIDTH_DEF;
    localparam longint unsigned MAG_MAX      = (64'd1 << (VW - 1)) - 1;
    localparam int unsigned     RANDOM_ITEMS = 1250;
    localparam int unsigned     HOLD_CYCLES  = 150;
    localparam int unsigned     DRAIN_CYCLES = 16;
    localparam int unsigned     CYCLE_LIMIT  = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dcnf_in_if  in_if ();
    dcnf_out_if out_if ();

    dimacs_cnf_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scoreboard model state
    t_mode           scan_st;
    logic [2:0]      hdr_sel;
    longint unsigned mag;
    bit              mag_neg;
    longint unsigned clause_cnt;
    logic [31:0]     hdr_clauses;
    t_result         byte_tokens[$];
    t_result         tokens_due[$];

    logic [7:0]      cnf_text[$];
    bit              calm = 1'b0;
    bit              hold_req = 1'b0;
    int unsigned     hold_left = 0;
    int unsigned     n_items = 0;
    int unsigned     n_tokens = 0;
    int unsigned     n_files = 0;
    int unsigned     fail_cnt = 0;
    int unsigned     cycle_cnt = 0;
    string           err_case = "none";

    function automatic bit blank(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic bit numeral(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void add_token(t_kind k, logic [31:0] v, logic m);
        t_result r;
        r.kind     = k;
        r.value    = v;
        r.mismatch = m;
        r.last     = 1'b0;
        if (byte_tokens.size() < 2)
            byte_tokens.push_back(r);
    endfunction

    function automatic void add_digit(logic [7:0] c);
        longint unsigned d;
        d = longint'(c) - longint'(CH_ZERO);
        if (mag > (MAG_MAX - d) / 10)
            mag = MAG_MAX;
        else
            mag = mag * 10 + d;
    endfunction

    function automatic void open_number(logic [7:0] c);
        mag_neg = (c == CH_MINUS);
        mag     = 0;
        if (numeral(c))
            add_digit(c);
    endfunction

    function automatic logic [31:0] number_word();
        return mag_neg ? 32'(64'd0 - mag) : 32'(mag);
    endfunction

    function automatic void close_count(logic [31:0] v);
        mag     = 0;
        mag_neg = 1'b0;
        if (hdr_sel == 3'd0) begin
            add_token(K_HVARS, v, 1'b0);
            hdr_sel = 3'd1;
            scan_st = M_HDR_PRE;
        end else begin
            add_token(K_HCLS, v, 1'b0);
            hdr_clauses = v;
            hdr_sel     = 3'd0;
            scan_st     = M_START;
        end
    endfunction

    function automatic void close_clause();
        add_token(K_CEND, 32'd0, 1'b0);
        if (clause_cnt < MAG_MAX)
            clause_cnt++;
    endfunction

    function automatic void clear_scan();
        scan_st     = M_START;
        hdr_sel     = 3'd0;
        mag         = 0;
        mag_neg     = 1'b0;
        clause_cnt  = 0;
        hdr_clauses = '0;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eot);
        bit fail;
        bit again;
        int pass;
        fail = 1'b0;
        byte_tokens.delete();
        if (scan_st == M_ERROR)
            return;
        if (eot) begin
            case (scan_st)
                M_COMMENT: fail = 1'b1;
                M_LIT: begin
                    if (mag != 0)
                        fail = 1'b1;
                    else
                        close_clause();
                end
                M_HDR_PRE: hdr_clauses = '0;
                M_HDR_DIG: hdr_clauses = (hdr_sel != 3'd0) ? number_word() : '0;
                default: ;
            endcase
            if (!fail) begin
                add_token(K_TOTAL, 32'(clause_cnt), 32'(clause_cnt) != hdr_clauses);
                clear_scan();
            end
        end else begin
            for (pass = 0; pass < 4; pass++) begin
                again = 1'b0;
                case (scan_st)
                    M_START: begin
                        if (c == CH_C) begin
                            scan_st = M_COMMENT;
                        end else if (c == CH_P) begin
                            scan_st = M_HSKIP;
                            hdr_sel = HDR_SKIP;
                        end else if ((c == CH_MINUS) || numeral(c)) begin
                            open_number(c);
                            scan_st = M_LIT;
                        end else if (!blank(c)) begin
                            fail = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_NEWLINE)
                            scan_st = M_START;
                    end
                    M_HSKIP: begin
                        hdr_sel = hdr_sel - 3'd1;
                        if (hdr_sel == 3'd0)
                            scan_st = M_HDR_PRE;
                    end
                    M_HDR_PRE: begin
                        if ((c == CH_MINUS) || numeral(c)) begin
                            open_number(c);
                            scan_st = M_HDR_DIG;
                        end else if (!blank(c)) begin
                            close_count(32'd0);
                            again = 1'b1;
                        end
                    end
                    M_HDR_DIG: begin
                        if (numeral(c)) begin
                            add_digit(c);
                        end else begin
                            close_count(number_word());
                            again = 1'b1;
                        end
                    end
                    M_LIT: begin
                        if (numeral(c)) begin
                            add_digit(c);
                        end else begin
                            if (mag == 0)
                                close_clause();
                            else
                                add_token(K_LIT, number_word(), 1'b0);
                            mag     = 0;
                            mag_neg = 1'b0;
                            scan_st = M_START;
                            again   = 1'b1;
                        end
                    end
                    default: scan_st = M_ERROR;
                endcase
                if (!again || fail)
                    break;
            end
        end
        if (fail) begin
            byte_tokens.delete();
            add_token(K_ERR, 32'd0, 1'b0);
            scan_st = M_ERROR;
        end
        foreach (byte_tokens[i]) begin
            byte_tokens[i].last = (i == byte_tokens.size() - 1);
            tokens_due.push_back(byte_tokens[i]);
        end
    endfunction

    // request monitor and token checker
    always @(posedge i_clk) begin
        t_result exp_tok;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_tokens(in_if.text_byte, in_if.end_of_text);
            n_items++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_tokens++;
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d value %0d", out_if.token_kind,
                       $signed(out_if.token_value));
                fail_cnt++;
            end else begin
                exp_tok = tokens_due.pop_front();
                if (out_if.token_kind !== exp_tok.kind) begin
                    $error("token_kind: expected %0d, got %0d", exp_tok.kind,
                           out_if.token_kind);
                    fail_cnt++;
                end
                if (out_if.token_value !== exp_tok.value) begin
                    $error("token_value: expected %0d, got %0d", $signed(exp_tok.value),
                           $signed(out_if.token_value));
                    fail_cnt++;
                end
                if (out_if.count_mismatch !== exp_tok.mismatch) begin
                    $error("count_mismatch: expected %0d, got %0d", exp_tok.mismatch,
                           out_if.count_mismatch);
                    fail_cnt++;
                end
                if (out_if.last_of_run !== exp_tok.last) begin
                    $error("last_of_run: expected %0d, got %0d", exp_tok.last,
                           out_if.last_of_run);
                    fail_cnt++;
                end
            end
        end
    end

    // token receiver: random stalls plus an optional long hold-off
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout: run stopped after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] b, logic eot);
        if (!calm) begin
            while ($urandom_range(0, 99) < 34) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid       <= 1'b1;
        in_if.text_byte   <= b;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_cnf();
        foreach (cnf_text[i])
            send_item(cnf_text[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        n_files++;
    endtask

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            cnf_text.push_back(s[i]);
    endfunction

    function automatic void put_gap(int unsigned lo);
        int unsigned r;
        repeat ($urandom_range(lo, 3)) begin
            r = $urandom_range(0, 7);
            cnf_text.push_back((r >= 5) ? CH_SPACE : 8'(CH_TAB + r));
        end
    endfunction

    function automatic void put_comment();
        logic [7:0] b;
        cnf_text.push_back(CH_C);
        repeat ($urandom_range(0, 8)) begin
            b = 8'($urandom_range(0, 255));
            cnf_text.push_back((b == CH_NEWLINE) ? 8'h00 : b);
        end
        cnf_text.push_back(CH_NEWLINE);
    endfunction

    function automatic void put_sep();
        if ($urandom_range(0, 9) == 0)
            put_comment();
        else
            put_gap(1);
    endfunction

    function automatic void put_number();
        int unsigned form;
        form = $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0)
            cnf_text.push_back(CH_MINUS);
        if (form == 0)
            put_str("000");
        if (form < 13)
            put_str($sformatf("%0d", $urandom_range(1, 60)));
        else if (form < 18)
            put_str($sformatf("%0d", $urandom));
        else if (form == 18)
            repeat ($urandom_range(10, 13))
                cnf_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        else
            put_str($sformatf("%0d", 64'd2147483646 + $urandom_range(0, 2)));
    endfunction

    task automatic send_random_cnf();
        int unsigned n_cls;
        int unsigned hdr_at;
        int unsigned keep;
        bit          cut;
        cnf_text.delete();
        cut   = ($urandom_range(0, 11) == 0);
        n_cls = $urandom_range(0, 6);
        if (!cut && ($urandom_range(0, 3) == 0))
            put_comment();
        hdr_at = cnf_text.size();
        if (cut || ($urandom_range(0, 9) != 0)) begin
            cnf_text.push_back(CH_P);
            if ($urandom_range(0, 3) == 0)
                repeat (4) cnf_text.push_back(8'($urandom_range(0, 255)));
            else
                put_str(" cnf");
            put_gap(0);
            if ($urandom_range(0, 11) == 0) begin
                put_comment();
            end else begin
                if ($urandom_range(0, 3) == 0)
                    put_number();
                else
                    put_str($sformatf("%0d", $urandom_range(1, 200)));
                put_gap(1);
                if ($urandom_range(0, 9) < 7)
                    put_str($sformatf("%0d", n_cls));
                else
                    put_number();
                put_gap(1);
            end
        end
        if (cut) begin
            keep = $urandom_range(hdr_at + 1, cnf_text.size());
            while (cnf_text.size() > keep)
                void'(cnf_text.pop_back());
        end else begin
            for (int k = 0; k < n_cls; k++) begin
                repeat ($urandom_range(0, 4)) begin
                    put_number();
                    put_sep();
                end
                case ($urandom_range(0, 9))
                    0:       cnf_text.push_back(CH_MINUS);
                    1:       put_str("-0");
                    2:       put_str("00");
                    default: put_str("0");
                endcase
                if ((k != n_cls - 1) || ($urandom_range(0, 9) < 7))
                    put_sep();
            end
        end
        send_cnf();
    endtask

    task automatic test_header_clause();
        cnf_text.delete();
        cnf_text.push_back(CH_P);
        cnf_text.push_back(8'h00);
        cnf_text.push_back(8'hFF);
        put_str("nf 1 1 -1 0");
        send_cnf();
    endtask

    task automatic test_missing_counts_minus_alone();
        cnf_text.delete();
        put_str("p cnf");
        cnf_text.push_back(CH_C);
        cnf_text.push_back(CH_NEWLINE);
        cnf_text.push_back(CH_MINUS);
        cnf_text.push_back(CH_SPACE);
        send_cnf();
    endtask

    task automatic test_output_stall();
        cnf_text.delete();
        repeat (30) put_str("-7 ");
        put_str("0");
        calm     = 1'b1;
        hold_req = 1'b1;
        send_cnf();
        calm = 1'b0;
    endtask

    task automatic test_random_files();
        int unsigned goal;
        goal = n_items + RANDOM_ITEMS;
        calm = 1'b1;
        repeat (4) send_random_cnf();
        calm = 1'b0;
        while (n_items < goal)
            send_random_cnf();
    endtask

    // the block stays silent after an error, so this runs last
    task automatic test_parse_error();
        int unsigned variant;
        logic [7:0]  bad;
        variant = $urandom_range(0, 3);
        do
            bad = 8'($urandom_range(0, 255));
        while (blank(bad) || numeral(bad) || (bad == CH_C) || (bad == CH_P) ||
               (bad == CH_MINUS));
        cnf_text.delete();
        case (variant)
            0: begin
                put_str("3");
                cnf_text.push_back(bad);
                err_case = "unexpected character after a literal";
            end
            1: begin
                put_str("p cnf 5");
                cnf_text.push_back(bad);
                err_case = "unexpected character inside a header";
            end
            2: begin
                put_str("c 1 2");
                err_case = "unterminated comment";
            end
            default: begin
                put_str("-12");
                err_case = "open literal at end of text";
            end
        endcase
        foreach (cnf_text[i])
            send_item(cnf_text[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), variant >= 2);
        send_item(CH_ZERO + 8'd1, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        in_if.valid <= 1'b0;
    endtask

    initial begin
        in_if.valid       <= 1'b0;
        in_if.text_byte   <= 8'h00;
        in_if.end_of_text <= 1'b0;
        clear_scan();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_clause();
        test_missing_counts_minus_alone();
        test_output_stall();
        test_random_files();
        test_parse_error();

        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d requests in %0d texts, %0d tokens checked", n_items, n_files,
                 n_tokens);
        $display("Summary: closing error case was %s", err_case);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
